// ===== rtl/cle_pkg.sv =====
// cle_pkg: shared types, codes and sizes of the console line editor
// depends on nothing; imported by every module of the block

package cle_pkg;

	// line buffer size and derived widths
	localparam int LINE_CAP = 256;
	localparam int ADDR_W   = $clog2(LINE_CAP);
	localparam int CNT_W    = $clog2(LINE_CAP + 1);
	localparam int LEN_W    = 9;

	// depth of the queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// console characters
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SP = 8'h20;

	// action codes on the input side
	localparam logic ACT_RX   = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// classified command handed from front to back
	typedef enum logic [1:0] {
		OP_READ,
		OP_ERASE,
		OP_ENTER,
		OP_STORE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;   // rx byte, or read index for OP_READ
		logic       is_lf;
	} cmd_t;

endpackage

// ===== rtl/cle_front.sv =====
// cle_front: accepts input transactions and classifies them into commands
// depends on cle_pkg

module cle_front import cle_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte [7:0], read_index [15:8]
	input  logic        s_tuser,   // action
	output logic        push_valid,
	input  logic        push_ready,
	output cmd_t        push_cmd
);

	logic [7:0] rx_byte;
	logic [7:0] read_index;

	assign rx_byte    = s_tdata[7:0];
	assign read_index = s_tdata[15:8];

	// handshake passes straight to the queue
	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	// command decode
	always_comb begin
		push_cmd.is_lf = (rx_byte == CH_LF);
		push_cmd.data  = rx_byte;
		if (s_tuser == ACT_READ) begin
			push_cmd.op   = OP_READ;
			push_cmd.data = read_index;
		end else if (rx_byte == CH_BS) begin
			push_cmd.op = OP_ERASE;
		end else if (rx_byte == CH_CR) begin
			push_cmd.op = OP_ENTER;
		end else begin
			push_cmd.op = OP_STORE;
		end
	end

endmodule

// ===== rtl/cle_queue.sv =====
// cle_queue: small command fifo between front and back
// depends on cle_pkg

module cle_queue import cle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// ===== rtl/cle_back.sv =====
// cle_back: executes commands on the line buffer and drives the result register
// depends on cle_pkg

module cle_back import cle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  cmd_t        pop_cmd,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte [7:0], line_length [16:8], zero [23:17]
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ECHO,
		ST_TRIM,
		ST_TWAIT,
		ST_DONE,
		ST_READ
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  done_len_q;
	logic [CNT_W-1:0]  trim_n_q;
	logic [7:0]        echo_q [3];
	logic [1:0]        echo_cnt_q;
	logic [1:0]        echo_pos_q;
	logic              finish_q;
	logic [7:0]        rd_idx_q;

	// result register
	logic              m_valid_q;
	logic [7:0]        m_byte_q;
	logic [LEN_W-1:0]  m_len_q;
	logic [1:0]        m_kind_q;
	logic              m_last_q;

	// line buffer
	logic [7:0]        line_mem [LINE_CAP];
	logic [7:0]        rd_data_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_ra;

	logic              pop;
	logic              out_ok;
	logic              emit;
	logic              room;
	logic [CNT_W-1:0]  new_cnt;
	logic              echo_end;
	logic              idx_hit;

	assign pop       = (state_q == ST_IDLE) && pop_valid;
	assign pop_ready = (state_q == ST_IDLE);
	assign out_ok    = !m_valid_q || m_tready;
	assign emit      = out_ok && (state_q inside {ST_ECHO, ST_DONE, ST_READ});
	assign room      = (count_q < CNT_W'(LINE_CAP));
	assign new_cnt   = room ? count_q + 1'b1 : count_q;
	assign echo_end  = (echo_pos_q == echo_cnt_q - 2'd1);
	assign idx_hit   = (32'(rd_idx_q) < 32'(done_len_q)) && (32'(rd_idx_q) < LINE_CAP);

	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {7'd0, m_len_q, m_byte_q};
	assign m_tuser   = m_kind_q;
	assign m_tlast   = m_last_q;

	// buffer port decode
	always_comb begin
		mem_we = pop && (pop_cmd.op == OP_STORE) && room;
		mem_wa = ADDR_W'(count_q);
		mem_re = 1'b0;
		mem_ra = ADDR_W'(pop_cmd.data);
		if (pop && (pop_cmd.op == OP_READ)) begin
			mem_re = 1'b1;
		end else if ((state_q == ST_TRIM) && (trim_n_q != '0)) begin
			mem_re = 1'b1;
			mem_ra = ADDR_W'(trim_n_q - 1'b1);
		end
	end

	// line buffer, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[mem_wa] <= pop_cmd.data;
		if (mem_re)
			rd_data_q <= line_mem[mem_ra];
	end

	// command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			done_len_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (emit)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						echo_pos_q <= '0;
						case (pop_cmd.op)
							OP_READ: begin
								rd_idx_q <= pop_cmd.data;
								state_q  <= ST_READ;
							end
							OP_ERASE: begin
								if (count_q != '0) begin
									count_q    <= count_q - 1'b1;
									echo_q[0]  <= CH_BS;
									echo_q[1]  <= CH_SP;
									echo_q[2]  <= CH_BS;
									echo_cnt_q <= 2'd3;
									finish_q   <= 1'b0;
									state_q    <= ST_ECHO;
								end
							end
							OP_ENTER: begin
								echo_q[0]  <= CH_LF;
								echo_q[1]  <= CH_CR;
								echo_cnt_q <= 2'd2;
								finish_q   <= 1'b1;
								state_q    <= ST_ECHO;
							end
							default: begin
								count_q    <= new_cnt;
								echo_q[0]  <= pop_cmd.data;
								echo_q[1]  <= CH_CR;
								echo_cnt_q <= pop_cmd.is_lf ? 2'd2 : 2'd1;
								finish_q   <= (new_cnt >= CNT_W'(LINE_CAP));
								state_q    <= ST_ECHO;
							end
						endcase
					end
				end
				ST_ECHO: begin
					if (out_ok) begin
						m_kind_q  <= KIND_ECHO;
						m_byte_q  <= echo_q[echo_pos_q];
						m_len_q   <= '0;
						m_last_q  <= echo_end && !finish_q;
						if (echo_end) begin
							if (finish_q) begin
								trim_n_q <= count_q;
								count_q  <= '0;
								state_q  <= ST_TRIM;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							echo_pos_q <= echo_pos_q + 2'd1;
						end
					end
				end
				// walk back over trailing spaces, one buffer read at a time
				ST_TRIM: begin
					state_q <= (trim_n_q == '0) ? ST_DONE : ST_TWAIT;
				end
				ST_TWAIT: begin
					if (rd_data_q == CH_SP) begin
						trim_n_q <= trim_n_q - 1'b1;
						state_q  <= ST_TRIM;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ok) begin
						m_kind_q   <= KIND_DONE;
						m_byte_q   <= '0;
						m_len_q    <= LEN_W'(trim_n_q);
						m_last_q   <= 1'b1;
						done_len_q <= trim_n_q;
						state_q    <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (out_ok) begin
						m_kind_q  <= KIND_READ;
						m_byte_q  <= idx_hit ? rd_data_q : 8'd0;
						m_len_q   <= '0;
						m_last_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/console_line_editor.sv =====
// console_line_editor: top level, front classifier, command queue and executor
// depends on cle_pkg, cle_front, cle_queue, cle_back
//
//  channel | direction | tdata                               | tuser  | tlast
//  s_*     | in        | rx_byte [7:0], read_index [15:8]     | action | -
//  m_*     | out       | out_byte [7:0], line_length [16:8]   | kind   | last
//
// the executor handles one command at a time over the buffer ports, be it a read,
// a stored byte or a backspace; a completed line adds a trim walk over its
// trailing spaces, one buffer read per space, since the buffer has a single
// registered read port
// reset clears the count, the length of the last line and all handshake state
// the two-entry queue takes up to two more transactions while results wait on m_tready

module console_line_editor import cle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte [7:0], read_index [15:8]
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte [7:0], line_length [16:8], zero [23:17]
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// classify incoming transactions
	cle_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	cle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// command execution and results
	cle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== rtl/cle_checker.sv =====
// cle_checker: port-level assertions for console_line_editor, bound to the top
// depends on cle_pkg

module cle_checker import cle_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// a line completion closes its input's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DONE) |-> m_tlast)
		else $error("line completion without last");

	// a read result closes its input's results
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_READ) |-> m_tlast)
		else $error("read result without last");

	// length field is zero outside completions, byte field zero on completions
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == KIND_DONE) ? (m_tdata[7:0] == 8'd0)
			: (m_tdata[16:8] == 9'd0)) && (m_tdata[23:17] == 7'd0))
		else $error("unused result field not zero");

	// only defined kinds leave the block
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_ECHO) || (m_tuser == KIND_DONE)
			|| (m_tuser == KIND_READ))
		else $error("undefined result kind");

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for console_line_editor, with line editing predicted in-bench
// depends on cle_pkg and the console_line_editor rtl; random stalls on both stream sides

module tb;
	import cle_pkg::*;

	localparam int WD_LIMIT    = 4000;
	localparam int TAIL_CYCLES = 600;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_ITEMS  = 30;

	// one input transaction, with a flag to wait for all echoes first
	typedef struct packed {
		logic       act;
		logic [7:0] rx;
		logic [7:0] idx;
		logic       drain;
	} key_t;

	// one output transaction as predicted
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             fin;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // rx_byte [7:0], read_index [15:8]
	logic        s_tuser = 1'b0; // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // out_byte [7:0], line_length [16:8], zero [23:17]
	logic [1:0]  m_tuser;        // kind
	logic        m_tlast;

	console_line_editor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted editor state
	logic [7:0]       line_buf [LINE_CAP];
	logic [CNT_W-1:0] edit_cnt = '0;
	logic [LEN_W-1:0] done_len = '0;
	res_t             echo_due [$];

	// stimulus and handshake bookkeeping
	key_t keys_q [$];
	key_t tx_key;
	logic pause_next = 1'b0;
	int   n_keys = 0;
	int   n_offered = 0;
	int   in_taken = 0;
	int   tx_gap = 0;
	logic tx_calm = 1'b0;
	int   rx_stall = 0;
	logic rx_calm = 1'b0;
	logic hold_done = 1'b0;
	int   bad_cnt = 0;
	int   quiet_cycles = 0;

	// trailing-space trim on line completion
	function automatic res_t close_line();
		int   n;
		res_t r;
		n = edit_cnt;
		while (n > 0 && line_buf[n-1] == CH_SP)
			n--;
		done_len = n[LEN_W-1:0];
		edit_cnt = '0;
		r = '{kind: KIND_DONE, data: 8'h00, len: n[LEN_W-1:0], fin: 1'b0};
		return r;
	endfunction

	// predict the output transactions of one accepted input
	function automatic void edit_and_echo(logic act, logic [7:0] c, logic [7:0] idx);
		res_t r [3];
		int   k;
		k = 0;
		if (act == ACT_READ) begin
			r[0] = '{kind: KIND_READ, data: (idx < done_len) ? line_buf[idx] : 8'h00,
				len: '0, fin: 1'b0};
			k = 1;
		end else if (c == CH_BS) begin
			if (edit_cnt > 0) begin
				edit_cnt = edit_cnt - 1'b1;
				r[0] = '{kind: KIND_ECHO, data: CH_BS, len: '0, fin: 1'b0};
				r[1] = '{kind: KIND_ECHO, data: CH_SP, len: '0, fin: 1'b0};
				r[2] = '{kind: KIND_ECHO, data: CH_BS, len: '0, fin: 1'b0};
				k = 3;
			end
		end else if (c == CH_CR) begin
			r[0] = '{kind: KIND_ECHO, data: CH_LF, len: '0, fin: 1'b0};
			r[1] = '{kind: KIND_ECHO, data: CH_CR, len: '0, fin: 1'b0};
			r[2] = close_line();
			k = 3;
		end else begin
			if (edit_cnt < LINE_CAP) begin
				line_buf[edit_cnt[ADDR_W-1:0]] = c;
				edit_cnt = edit_cnt + 1'b1;
			end
			r[k] = '{kind: KIND_ECHO, data: c, len: '0, fin: 1'b0};
			k++;
			if (c == CH_LF) begin
				r[k] = '{kind: KIND_ECHO, data: CH_CR, len: '0, fin: 1'b0};
				k++;
			end
			if (edit_cnt >= LINE_CAP) begin
				r[k] = close_line();
				k++;
			end
		end
		if (k > 0)
			r[k-1].fin = 1'b1;
		for (int i = 0; i < k; i++)
			echo_due.push_back(r[i]);
	endfunction

	// stimulus builders; the unused field gets random bits
	task automatic add_key(logic [7:0] c);
		key_t k;
		k = '{act: ACT_RX, rx: c, idx: 8'($urandom), drain: pause_next};
		pause_next = 1'b0;
		keys_q.push_back(k);
	endtask

	task automatic add_read(logic [7:0] i);
		key_t k;
		k = '{act: ACT_READ, rx: 8'($urandom), idx: i, drain: pause_next};
		pause_next = 1'b0;
		keys_q.push_back(k);
	endtask

	// a byte that gets stored: mostly printable, sometimes anything but bs and cr
	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		if ($urandom_range(0, 7) != 0)
			return 8'($urandom_range(8'h20, 8'h7e));
		do
			c = 8'($urandom);
		while (c == CH_BS || c == CH_CR);
		return c;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input driver, changes on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken == n_offered) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (keys_q.size() != 0 && !(keys_q[0].drain && echo_due.size() != 0)) begin
				tx_key = keys_q.pop_front();
				s_tdata <= {tx_key.idx, tx_key.rx};
				s_tuser <= tx_key.act;
				s_tvalid <= 1'b1;
				n_offered <= n_offered + 1;
				if ($urandom_range(0, 63) == 0)
					tx_calm = !tx_calm;
				tx_gap <= tx_calm ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready, with one long hold-off so the input side backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && in_taken >= 30) begin
			hold_done <= 1'b1;
			rx_stall <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
			if (rx_calm || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_stall <= pick_gap();
			end
		end
	end

	// accepted inputs feed the prediction, accepted outputs are checked
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				edit_and_echo(s_tuser, s_tdata[7:0], s_tdata[15:8]);
				in_taken = in_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				got = '{kind: m_tuser, data: m_tdata[7:0], len: m_tdata[16:8], fin: m_tlast};
				if (echo_due.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("unexpected transaction: kind %0d byte %02h len %0d last %0b",
							got.kind, got.data, got.len, got.fin);
				end else begin
					want = echo_due.pop_front();
					if (got !== want || m_tdata[23:17] !== '0) begin
						bad_cnt++;
						if (bad_cnt <= 10)
							$display("mismatch: exp kind %0d byte %02h len %0d last %0b, got kind %0d byte %02h len %0d last %0b pad %02h",
								want.kind, want.data, want.len, want.fin,
								got.kind, got.data, got.len, got.fin, m_tdata[23:17]);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("[console_line_editor] ERROR");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int base;
		int len;
		int sel;
		logic mid_pause;
		mid_pause = 1'b0;
		for (int i = 0; i < LINE_CAP; i++)
			line_buf[i] = 8'h00;

		// directed: reads before any line, empty backspace, edits, trims
		add_read(8'd0);
		add_read(8'd255);
		add_key(CH_BS);
		add_key(CH_CR);
		add_key(8'h00);
		add_key(8'hff);
		add_key(CH_LF);
		add_key(CH_SP);
		add_key(CH_BS);
		add_key(8'h61);
		add_key(CH_SP);
		add_key(CH_SP);
		add_key(CH_CR);
		add_read(8'd0);
		add_read(8'd3);
		add_read(8'd4);
		add_read(8'd255);
		// all-space line; read in between sees the overwritten byte
		add_key(CH_SP);
		add_key(CH_SP);
		add_read(8'd1);
		add_key(CH_CR);
		add_read(8'd0);

		// a line that fills the buffer, ending in a newline
		for (int i = 0; i < LINE_CAP - 1; i++)
			add_key(pick_char());
		add_key(CH_LF);
		add_read(8'd255);
		add_read(8'd0);
		add_read(8'd128);

		// random part: mostly well-formed lines with edits, plus reads and noise
		base = keys_q.size();
		while (keys_q.size() < base + RAND_ITEMS) begin
			if ($urandom_range(0, 24) == 0 || !mid_pause) begin
				pause_next = 1'b1;
				mid_pause = 1'b1;
			end
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 8);
				for (int i = 0; i < len; i++) begin
					add_key(pick_char());
					if ($urandom_range(0, 5) == 0)
						add_key(CH_BS);
				end
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 3)) add_key(CH_SP);
				add_key(CH_CR);
				repeat ($urandom_range(0, 3)) add_read(8'($urandom_range(0, len + 1)));
			end else if (sel < 8) begin
				repeat ($urandom_range(1, 3)) add_read(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 5)) add_key(8'($urandom));
			end
		end
		n_keys = keys_q.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (in_taken < n_keys || echo_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (echo_due.size() != 0) begin
			bad_cnt += echo_due.size();
			$display("%0d expected transactions never arrived", echo_due.size());
		end
		if (bad_cnt == 0)
			$display("[console_line_editor] OK");
		else
			$display("[console_line_editor] ERROR");
		$finish;
	end

endmodule
